>>> rtl/jtg_pkg.sv
// Shared constants, codes and types for the JSON token grammar checker.
package jtg_pkg;

  // Field widths
  localparam int KIND_W   = 4;
  localparam int START_W  = 32;
  localparam int LENGTH_W = 16;
  localparam int EVENT_W  = 4;
  localparam int STATUS_W = 2;

  // Default nesting bound
  localparam int MAX_NESTING_DEF = 16;

  // Token kinds
  localparam logic [KIND_W-1:0] TK_OBJ_BEGIN = 4'd0;
  localparam logic [KIND_W-1:0] TK_OBJ_END   = 4'd1;
  localparam logic [KIND_W-1:0] TK_ARR_BEGIN = 4'd2;
  localparam logic [KIND_W-1:0] TK_ARR_END   = 4'd3;
  localparam logic [KIND_W-1:0] TK_STRING    = 4'd4;
  localparam logic [KIND_W-1:0] TK_NUMBER    = 4'd5;
  localparam logic [KIND_W-1:0] TK_TRUE      = 4'd6;
  localparam logic [KIND_W-1:0] TK_FALSE     = 4'd7;
  localparam logic [KIND_W-1:0] TK_NULL      = 4'd8;
  localparam logic [KIND_W-1:0] TK_COLON     = 4'd9;
  localparam logic [KIND_W-1:0] TK_COMMA     = 4'd10;

  // Event kinds
  localparam logic [EVENT_W-1:0] EV_NONE      = 4'd0;
  localparam logic [EVENT_W-1:0] EV_OBJ_BEGIN = 4'd1;
  localparam logic [EVENT_W-1:0] EV_OBJ_END   = 4'd2;
  localparam logic [EVENT_W-1:0] EV_ARR_BEGIN = 4'd3;
  localparam logic [EVENT_W-1:0] EV_ARR_END   = 4'd4;
  localparam logic [EVENT_W-1:0] EV_KEY       = 4'd5;
  localparam logic [EVENT_W-1:0] EV_STRING    = 4'd6;
  localparam logic [EVENT_W-1:0] EV_NUMBER    = 4'd7;
  localparam logic [EVENT_W-1:0] EV_BOOL      = 4'd8;
  localparam logic [EVENT_W-1:0] EV_NULL      = 4'd9;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

  // Context kinds held on the stack
  localparam logic CTX_OBJ = 1'b0;
  localparam logic CTX_ARR = 1'b1;

  // Stack operation from the grammar logic to the context stack
  typedef struct packed {
    logic push;
    logic pop;
    logic kind;
  } stack_op_t;

  // One result item
  typedef struct packed {
    logic [EVENT_W-1:0]  event_kind;
    logic                bool_value;
    logic [START_W-1:0]  event_start;
    logic [LENGTH_W-1:0] event_length;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

>>> rtl/jtg_ifs.sv
// Valid/ready channel interfaces for tokens and events.
interface jtg_token_if;
  logic                         valid;
  logic                         ready;
  logic [jtg_pkg::KIND_W-1:0]   token_kind;
  logic [jtg_pkg::START_W-1:0]  token_start;
  logic [jtg_pkg::LENGTH_W-1:0] token_length;

  modport source (output valid, token_kind, token_start, token_length, input ready);
  modport sink   (input valid, token_kind, token_start, token_length, output ready);
endinterface

interface jtg_event_if;
  logic                         valid;
  logic                         ready;
  logic [jtg_pkg::EVENT_W-1:0]  event_kind;
  logic                         bool_value;
  logic [jtg_pkg::START_W-1:0]  event_start;
  logic [jtg_pkg::LENGTH_W-1:0] event_length;
  logic [jtg_pkg::STATUS_W-1:0] status;

  modport source (output valid, event_kind, bool_value, event_start, event_length, status,
                  input ready);
  modport sink   (input valid, event_kind, bool_value, event_start, event_length, status,
                  output ready);
endinterface

>>> rtl/jtg_ctx_stack.sv
// Context stack as a shift register: top entry at index zero.
module jtg_ctx_stack #(
  parameter int MAX_NESTING = jtg_pkg::MAX_NESTING_DEF
) (
  input  logic              clk,
  input  jtg_pkg::stack_op_t op,
  output logic              top_kind
);

  logic [MAX_NESTING-1:0] stack_r;
  logic [MAX_NESTING-1:0] stack_nxt;
  logic [MAX_NESTING:0]   shift_in;
  logic [MAX_NESTING:0]   shift_out;

  // Push shifts deeper, pop shifts toward the top
  assign shift_in  = {stack_r, op.kind};
  assign shift_out = {1'b0, stack_r};

  always_comb begin
    stack_nxt = stack_r;
    if (op.push) begin
      stack_nxt = shift_in[MAX_NESTING-1:0];
    end else if (op.pop) begin
      stack_nxt = shift_out[MAX_NESTING:1];
    end
  end

  always_ff @(posedge clk) begin
    stack_r <= stack_nxt;
  end

  assign top_kind = stack_r[0];

endmodule

>>> rtl/jtg_grammar.sv
// Grammar state: expectation, nesting level, sticky flags and per-token decision.
module jtg_grammar #(
  parameter int MAX_NESTING = jtg_pkg::MAX_NESTING_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic [jtg_pkg::KIND_W-1:0]   kind,
  input  logic [jtg_pkg::START_W-1:0]  start,
  input  logic [jtg_pkg::LENGTH_W-1:0] length,
  output jtg_pkg::result_t             res
);

  localparam int LVL_W = $clog2(MAX_NESTING + 1);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_NESTING);

  typedef enum logic [1:0] {
    EXP_VALUE = 2'd0,
    EXP_KEY   = 2'd1,
    EXP_COLON = 2'd2,
    EXP_NEXT  = 2'd3
  } expect_t;

  expect_t          expect_r, expect_nxt, exp_tok;
  logic [LVL_W-1:0] level_r, level_nxt, level_tok;
  logic             error_r, error_nxt;
  logic             done_r, done_nxt;
  logic             ok;
  logic             top_kind;
  jtg_pkg::stack_op_t op_tok, op;
  jtg_pkg::result_t   res_tok;

  jtg_ctx_stack #(
    .MAX_NESTING (MAX_NESTING)
  ) u_stack (
    .clk      (clk),
    .op       (op),
    .top_kind (top_kind)
  );

  // Decide the token against the current expectation
  always_comb begin
    ok        = 1'b0;
    exp_tok   = expect_r;
    level_tok = level_r;
    op_tok    = '0;
    res_tok   = '0;
    case (kind)
      jtg_pkg::TK_OBJ_BEGIN, jtg_pkg::TK_ARR_BEGIN: begin
        res_tok.event_kind = (kind == jtg_pkg::TK_OBJ_BEGIN) ? jtg_pkg::EV_OBJ_BEGIN
                                                             : jtg_pkg::EV_ARR_BEGIN;
        if (expect_r == EXP_VALUE && level_r < LVL_MAX) begin
          ok          = 1'b1;
          op_tok.push = 1'b1;
          op_tok.kind = (kind == jtg_pkg::TK_OBJ_BEGIN) ? jtg_pkg::CTX_OBJ : jtg_pkg::CTX_ARR;
          level_tok   = level_r + 1'b1;
          exp_tok     = (kind == jtg_pkg::TK_OBJ_BEGIN) ? EXP_KEY : EXP_VALUE;
        end
      end
      jtg_pkg::TK_OBJ_END, jtg_pkg::TK_ARR_END: begin
        res_tok.event_kind = (kind == jtg_pkg::TK_OBJ_END) ? jtg_pkg::EV_OBJ_END
                                                           : jtg_pkg::EV_ARR_END;
        if (level_r != '0 &&
            top_kind == ((kind == jtg_pkg::TK_OBJ_END) ? jtg_pkg::CTX_OBJ : jtg_pkg::CTX_ARR)) begin
          ok         = 1'b1;
          op_tok.pop = 1'b1;
          level_tok  = level_r - 1'b1;
          exp_tok    = EXP_NEXT;
        end
      end
      jtg_pkg::TK_STRING: begin
        res_tok.event_start  = start;
        res_tok.event_length = length;
        if (expect_r == EXP_KEY) begin
          ok                 = 1'b1;
          exp_tok            = EXP_COLON;
          res_tok.event_kind = jtg_pkg::EV_KEY;
        end else begin
          ok                 = (expect_r == EXP_VALUE);
          exp_tok            = EXP_NEXT;
          res_tok.event_kind = jtg_pkg::EV_STRING;
        end
      end
      jtg_pkg::TK_NUMBER: begin
        ok                   = (expect_r == EXP_VALUE);
        exp_tok              = EXP_NEXT;
        res_tok.event_kind   = jtg_pkg::EV_NUMBER;
        res_tok.event_start  = start;
        res_tok.event_length = length;
      end
      jtg_pkg::TK_TRUE, jtg_pkg::TK_FALSE: begin
        ok                 = (expect_r == EXP_VALUE);
        exp_tok            = EXP_NEXT;
        res_tok.event_kind = jtg_pkg::EV_BOOL;
        res_tok.bool_value = (kind == jtg_pkg::TK_TRUE);
      end
      jtg_pkg::TK_NULL: begin
        ok                 = (expect_r == EXP_VALUE);
        exp_tok            = EXP_NEXT;
        res_tok.event_kind = jtg_pkg::EV_NULL;
      end
      jtg_pkg::TK_COLON: begin
        ok      = (expect_r == EXP_COLON);
        exp_tok = EXP_VALUE;
      end
      jtg_pkg::TK_COMMA: begin
        ok      = (expect_r == EXP_NEXT) && (level_r != '0);
        exp_tok = (top_kind == jtg_pkg::CTX_OBJ) ? EXP_KEY : EXP_VALUE;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Apply sticky flags and commit only accepted tokens
  always_comb begin
    expect_nxt = expect_r;
    level_nxt  = level_r;
    error_nxt  = error_r;
    done_nxt   = done_r;
    op         = '0;
    res        = '0;
    if (error_r) begin
      res.status = jtg_pkg::ST_ERROR;
    end else if (done_r) begin
      res.status = jtg_pkg::ST_DONE;
    end else if (!ok) begin
      res.status = jtg_pkg::ST_ERROR;
      if (step_en) begin
        error_nxt = 1'b1;
      end
    end else begin
      res = res_tok;
      if (exp_tok == EXP_NEXT && level_tok == '0) begin
        res.status = jtg_pkg::ST_DONE;
      end else begin
        res.status = jtg_pkg::ST_OK;
      end
      if (step_en) begin
        expect_nxt = exp_tok;
        level_nxt  = level_tok;
        op         = op_tok;
        done_nxt   = (exp_tok == EXP_NEXT && level_tok == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= EXP_VALUE;
      level_r  <= '0;
      error_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      expect_r <= expect_nxt;
      level_r  <= level_nxt;
      error_r  <= error_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

>>> rtl/json_token_grammar_checker.sv
// Top level: token input register, grammar stage and event result register.
// Streaming JSON grammar checker. Takes one token per transfer on in_tok and returns
// exactly one event per token on out_evt, in order. It sustains one token per clock:
// the token lands in an input register, then the grammar logic decides it,
// updates the expectation state, nesting level and context stack in the same cycle,
// and loads the result register, which raises output valid. The rate is set by that
// state update loop. Back pressure on out_evt stalls the result register and then the
// input register. The context stack holds MAX_NESTING entries; a begin token beyond
// that depth is an error. Status is sticky: after an error every token reports error,
// after a completed document every token reports done, both with event none. A reset
// clears the checker for a new document.
module json_token_grammar_checker #(
  parameter int MAX_NESTING = jtg_pkg::MAX_NESTING_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  jtg_token_if.sink   in_tok,
  jtg_event_if.source out_evt
);

  logic                         in_valid_r, in_valid_nxt;
  logic [jtg_pkg::KIND_W-1:0]   kind_r;
  logic [jtg_pkg::START_W-1:0]  start_r;
  logic [jtg_pkg::LENGTH_W-1:0] length_r;
  logic                         out_valid_r, out_valid_nxt;
  jtg_pkg::result_t             res_r;
  jtg_pkg::result_t             res;
  logic                         advance;
  logic                         in_xfer;

  // Move the held token into the result stage when the result register frees up
  assign advance      = in_valid_r && (!out_valid_r || out_evt.ready);
  assign in_tok.ready = !in_valid_r || advance;
  assign in_xfer      = in_tok.valid && in_tok.ready;

  jtg_grammar #(
    .MAX_NESTING (MAX_NESTING)
  ) u_grammar (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .kind    (kind_r),
    .start   (start_r),
    .length  (length_r),
    .res     (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_evt.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r   <= in_tok.token_kind;
      start_r  <= in_tok.token_start;
      length_r <= in_tok.token_length;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_evt.valid        = out_valid_r;
  assign out_evt.event_kind   = res_r.event_kind;
  assign out_evt.bool_value   = res_r.bool_value;
  assign out_evt.event_start  = res_r.event_start;
  assign out_evt.event_length = res_r.event_length;
  assign out_evt.status       = res_r.status;

endmodule

>>> dv/jtg_tb_pkg.sv
`timescale 1ns / 100ps
// Grammar expectation codes and extra token kinds shared by the checker and the stimulus.
package jtg_tb_pkg;

  // What the grammar accepts next
  typedef enum logic [1:0] {
    WANT_VALUE = 2'd0,
    WANT_KEY   = 2'd1,
    WANT_COLON = 2'd2,
    WANT_NEXT  = 2'd3
  } want_t;

  // Token kinds that the grammar never accepts; after a document every token reports done
  localparam logic [3:0] TK_UNKNOWN   = 4'd11;
  localparam logic [3:0] TK_LEX_ERROR = 4'd12;
  localparam logic [3:0] TK_EOI       = 4'd13;
  localparam logic [3:0] TK_RSVD_14   = 4'd14;
  localparam logic [3:0] TK_RSVD_15   = 4'd15;

endpackage

>>> dv/jtg_grammar_checker.sv
`timescale 1ns / 100ps
// Passive checker: predicts one event per token transfer and compares event transfers in order.
module jtg_grammar_checker #(
  parameter int MAX_NESTING = jtg_pkg::MAX_NESTING_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  jtg_token_if        tok,
  jtg_event_if        evt,
  output int unsigned fail_count,
  output int unsigned pending
);
  import jtg_pkg::*;
  import jtg_tb_pkg::*;

  result_t     expected_events [$];
  result_t     want_evt;
  want_t       want;
  logic        ctx_stack [MAX_NESTING];
  int unsigned level;
  logic        err_seen;
  logic        doc_done;
  int unsigned fails = 0;
  int unsigned queued = 0;

  assign fail_count = fails;
  assign pending    = queued;

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  // Advance the grammar state by one token and return the event it produces
  function automatic result_t grammar_step(logic [KIND_W-1:0] kind,
                                           logic [START_W-1:0] tstart,
                                           logic [LENGTH_W-1:0] tlen);
    result_t r;
    logic ok;
    logic pass_pos;
    logic bval;
    logic [EVENT_W-1:0] ev;
    r        = '0;
    ok       = 1'b0;
    pass_pos = 1'b0;
    bval     = 1'b0;
    ev       = EV_NONE;
    if (err_seen) begin
      r.status = ST_ERROR;
    end else if (doc_done) begin
      r.status = ST_DONE;
    end else begin
      case (kind)
        TK_OBJ_BEGIN, TK_ARR_BEGIN: begin
          ev = (kind == TK_OBJ_BEGIN) ? EV_OBJ_BEGIN : EV_ARR_BEGIN;
          if (want == WANT_VALUE && level < MAX_NESTING) begin
            ctx_stack[level] = (kind == TK_OBJ_BEGIN) ? CTX_OBJ : CTX_ARR;
            level++;
            want = (kind == TK_OBJ_BEGIN) ? WANT_KEY : WANT_VALUE;
            ok   = 1'b1;
          end
        end
        // An end token checks only the innermost context, not the expectation
        TK_OBJ_END, TK_ARR_END: begin
          ev = (kind == TK_OBJ_END) ? EV_OBJ_END : EV_ARR_END;
          if (level > 0 &&
              ctx_stack[level-1] == ((kind == TK_OBJ_END) ? CTX_OBJ : CTX_ARR)) begin
            level--;
            want = WANT_NEXT;
            ok   = 1'b1;
          end
        end
        TK_STRING: begin
          pass_pos = 1'b1;
          if (want == WANT_KEY) begin
            ev   = EV_KEY;
            want = WANT_COLON;
            ok   = 1'b1;
          end else begin
            ev = EV_STRING;
            if (want == WANT_VALUE) begin
              want = WANT_NEXT;
              ok   = 1'b1;
            end
          end
        end
        TK_NUMBER, TK_TRUE, TK_FALSE, TK_NULL: begin
          case (kind)
            TK_NUMBER: ev = EV_NUMBER;
            TK_NULL:   ev = EV_NULL;
            default:   ev = EV_BOOL;
          endcase
          pass_pos = (kind == TK_NUMBER);
          bval     = (kind == TK_TRUE);
          if (want == WANT_VALUE) begin
            want = WANT_NEXT;
            ok   = 1'b1;
          end
        end
        TK_COLON: begin
          if (want == WANT_COLON) begin
            want = WANT_VALUE;
            ok   = 1'b1;
          end
        end
        TK_COMMA: begin
          if (want == WANT_NEXT && level > 0) begin
            want = (ctx_stack[level-1] == CTX_OBJ) ? WANT_KEY : WANT_VALUE;
            ok   = 1'b1;
          end
        end
        default: ok = 1'b0;
      endcase

      if (!ok) begin
        err_seen = 1'b1;
        r.status = ST_ERROR;
      end else if (want == WANT_NEXT && level == 0) begin
        doc_done = 1'b1;
        r.status = ST_DONE;
      end else begin
        r.status = ST_OK;
      end
    end

    // Rejected and sticky tokens carry no event
    if (ok) begin
      r.event_kind   = ev;
      r.bool_value   = bval;
      r.event_start  = pass_pos ? tstart : '0;
      r.event_length = pass_pos ? tlen : '0;
    end
    return r;
  endfunction

  // Compare result transfers, then queue the prediction for a token transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      want     = WANT_VALUE;
      level    = 0;
      err_seen = 1'b0;
      doc_done = 1'b0;
      expected_events.delete();
    end else begin
      if (evt.valid && evt.ready) begin
        if (expected_events.size() == 0) begin
          $error("event transfer with nothing expected: event_kind %0d status %0d",
                 evt.event_kind, evt.status);
          fails++;
        end else begin
          want_evt = expected_events.pop_front();
          check_field("event_kind", want_evt.event_kind, evt.event_kind);
          check_field("bool_value", want_evt.bool_value, evt.bool_value);
          check_field("event_start", want_evt.event_start, evt.event_start);
          check_field("event_length", want_evt.event_length, evt.event_length);
          check_field("status", want_evt.status, evt.status);
        end
      end
      if (tok.valid && tok.ready) begin
        expected_events.push_back(grammar_step(tok.token_kind, tok.token_start,
                                               tok.token_length));
      end
    end
    queued <= expected_events.size();
  end

endmodule

>>> dv/json_token_grammar_checker_tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, grammar-aware token stimulus, back pressure and verdict.
module json_token_grammar_checker_tb;
  import jtg_pkg::*;
  import jtg_tb_pkg::*;

  localparam int NEST         = MAX_NESTING_DEF;
  localparam int DOC_ITEMS    = 1150;
  localparam int TAIL_ITEMS   = 60;
  localparam int PHASE_LEN    = 100;
  localparam int DIVE_LEN     = 90;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  // Idle and stall odds in percent, one pair per traffic phase
  localparam int unsigned IDLE_PCT  [4] = '{0, 85, 0, 21};
  localparam int unsigned STALL_PCT [4] = '{0, 0, 85, 21};

  // How the document is finished off
  typedef enum int {
    END_CLOSE, END_OVERFLOW, END_MISMATCH, END_BAD_TOKEN, END_EARLY_EOI
  } ending_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        evt_ready = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned sent = 0;
  int unsigned fail_count;
  int unsigned pending;

  // Grammar position of the stimulus document
  want_t       gen_want = WANT_VALUE;
  int          gen_depth = 0;
  logic        gen_ctx [NEST];
  bit          dive = 1'b0;

  jtg_token_if in_tok ();
  jtg_event_if out_evt ();

  json_token_grammar_checker #(.MAX_NESTING(NEST)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tok  (in_tok),
    .out_evt (out_evt)
  );

  jtg_grammar_checker #(.MAX_NESTING(NEST)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok        (in_tok),
    .evt        (out_evt),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at the rate of the current phase
  assign out_evt.ready = evt_ready;
  always @(posedge clk) begin
    evt_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Drive one token and hold it until its transfer
  task automatic send_token(input logic [KIND_W-1:0] kind, input logic [START_W-1:0] tstart,
                            input logic [LENGTH_W-1:0] tlen);
    idle_pct  = IDLE_PCT[(sent / PHASE_LEN) % 4];
    stall_pct <= STALL_PCT[(sent / PHASE_LEN) % 4];
    while ($urandom_range(99) < idle_pct) begin
      in_tok.valid <= 1'b0;
      @(posedge clk);
    end
    in_tok.valid        <= 1'b1;
    in_tok.token_kind   <= kind;
    in_tok.token_start  <= tstart;
    in_tok.token_length <= tlen;
    @(posedge clk);
    while (!in_tok.ready) @(posedge clk);
    sent++;
  endtask

  // Follow a legal token through the grammar
  function automatic void track(logic [KIND_W-1:0] kind);
    case (kind)
      TK_OBJ_BEGIN, TK_ARR_BEGIN: begin
        gen_ctx[gen_depth] = (kind == TK_OBJ_BEGIN) ? CTX_OBJ : CTX_ARR;
        gen_depth++;
        gen_want = (kind == TK_OBJ_BEGIN) ? WANT_KEY : WANT_VALUE;
      end
      TK_OBJ_END, TK_ARR_END: begin
        gen_depth--;
        gen_want = WANT_NEXT;
      end
      TK_STRING: gen_want = (gen_want == WANT_KEY) ? WANT_COLON : WANT_NEXT;
      TK_COLON:  gen_want = WANT_VALUE;
      TK_COMMA:  gen_want = (gen_ctx[gen_depth-1] == CTX_OBJ) ? WANT_KEY : WANT_VALUE;
      default:   gen_want = WANT_NEXT;
    endcase
  endfunction

  task automatic emit(input logic [KIND_W-1:0] kind, input logic [START_W-1:0] tstart,
                      input logic [LENGTH_W-1:0] tlen);
    send_token(kind, tstart, tlen);
    track(kind);
  endtask

  task automatic emit_rand(input logic [KIND_W-1:0] kind);
    emit(kind, $urandom, LENGTH_W'($urandom_range(65535)));
  endtask

  function automatic logic [KIND_W-1:0] close_kind();
    return (gen_ctx[gen_depth-1] == CTX_OBJ) ? TK_OBJ_END : TK_ARR_END;
  endfunction

  // Pick a legal next token; dives push the nesting toward its limit
  function automatic logic [KIND_W-1:0] pick_token(bit allow_last_close);
    int unsigned r;
    int unsigned open_pct;
    int unsigned close_pct;
    bit can_close;
    r         = $urandom_range(99);
    open_pct  = dive ? 65 : 20;
    close_pct = dive ? 10 : 45;
    can_close = (gen_depth > 1) || allow_last_close;
    case (gen_want)
      WANT_VALUE: begin
        if (gen_depth < NEST && r < open_pct)
          return $urandom_range(1) ? TK_OBJ_BEGIN : TK_ARR_BEGIN;
        if (can_close && r >= 90)
          return close_kind();
        case ($urandom_range(4))
          0:       return TK_STRING;
          1:       return TK_NUMBER;
          2:       return TK_TRUE;
          3:       return TK_FALSE;
          default: return TK_NULL;
        endcase
      end
      WANT_KEY:   return (can_close && r < 15) ? close_kind() : TK_STRING;
      WANT_COLON: return (can_close && r < 8) ? close_kind() : TK_COLON;
      default:    return (can_close && r < close_pct) ? close_kind() : TK_COMMA;
    endcase
  endfunction

  initial begin
    ending_t ending;
    in_tok.valid        = 1'b0;
    in_tok.token_kind   = TK_OBJ_BEGIN;
    in_tok.token_start  = '0;
    in_tok.token_length = '0;
    rst_n               = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every value kind, empty containers, trailing comma, field extremes
    emit(TK_OBJ_BEGIN, 32'h0, 16'h1);
    emit(TK_STRING, 32'hFFFF_FFFF, 16'hFFFF);
    emit(TK_COLON, 32'h1, 16'h1);
    emit(TK_ARR_BEGIN, 32'h2, 16'h1);
    emit(TK_ARR_END, 32'h3, 16'h1);
    emit(TK_COMMA, 32'h4, 16'h1);
    emit(TK_STRING, 32'h0, 16'h0);
    emit(TK_COLON, 32'h5, 16'h1);
    emit(TK_ARR_BEGIN, 32'h6, 16'h1);
    emit(TK_NUMBER, 32'h0, 16'h0);
    emit(TK_COMMA, 32'h7, 16'h1);
    emit(TK_TRUE, 32'h8, 16'h4);
    emit(TK_COMMA, 32'hC, 16'h1);
    emit(TK_FALSE, 32'hD, 16'h5);
    emit(TK_COMMA, 32'h12, 16'h1);
    emit(TK_NULL, 32'h13, 16'h4);
    emit(TK_COMMA, 32'h17, 16'h1);
    emit(TK_STRING, 32'h5555_5555, 16'hAAAA);
    emit(TK_COMMA, 32'h18, 16'h1);
    emit(TK_OBJ_BEGIN, 32'h19, 16'h1);
    emit(TK_OBJ_END, 32'h1A, 16'h1);
    emit(TK_COMMA, 32'h1B, 16'h1);
    emit(TK_ARR_END, 32'h1C, 16'h1);
    emit(TK_COMMA, 32'h1D, 16'h1);
    emit(TK_STRING, 32'hAAAA_AAAA, 16'h5555);
    emit(TK_COLON, 32'h1E, 16'h1);
    emit(TK_NUMBER, 32'hFFFF_FFFF, 16'hFFFF);

    // Random well-formed body; the outer object stays open
    for (int i = 0; i < DOC_ITEMS; i++) begin
      if (i % DIVE_LEN == 0) dive = $urandom_range(1);
      emit_rand(pick_token(1'b0));
    end

    // Finish the document or break it
    ending = ending_t'($urandom_range(4));
    case (ending)
      END_CLOSE: begin
        while (gen_depth > 0) emit_rand(close_kind());
        send_token(TK_EOI, $urandom, LENGTH_W'($urandom_range(65535)));
      end
      END_OVERFLOW: begin
        if (gen_want == WANT_NEXT)  emit_rand(TK_COMMA);
        if (gen_want == WANT_KEY)   emit_rand(TK_STRING);
        if (gen_want == WANT_COLON) emit_rand(TK_COLON);
        while (gen_depth < NEST) emit_rand(TK_ARR_BEGIN);
        send_token($urandom_range(1) ? TK_OBJ_BEGIN : TK_ARR_BEGIN, $urandom,
                   LENGTH_W'($urandom_range(65535)));
      end
      END_MISMATCH: begin
        send_token((close_kind() == TK_OBJ_END) ? TK_ARR_END : TK_OBJ_END, $urandom,
                   LENGTH_W'($urandom_range(65535)));
      end
      END_BAD_TOKEN: begin
        case ($urandom_range(4))
          0: send_token(TK_UNKNOWN, $urandom, LENGTH_W'($urandom_range(65535)));
          1: send_token(TK_LEX_ERROR, $urandom, LENGTH_W'($urandom_range(65535)));
          2: send_token(TK_RSVD_14, $urandom, LENGTH_W'($urandom_range(65535)));
          3: send_token(TK_RSVD_15, $urandom, LENGTH_W'($urandom_range(65535)));
          default: send_token((gen_want == WANT_COLON) ? TK_COMMA : TK_COLON, $urandom,
                              LENGTH_W'($urandom_range(65535)));
        endcase
      end
      default: send_token(TK_EOI, $urandom, LENGTH_W'($urandom_range(65535)));
    endcase

    // Noise after the document must stay sticky
    repeat (TAIL_ITEMS) begin
      send_token(KIND_W'($urandom_range(15)), $urandom, LENGTH_W'($urandom_range(65535)));
    end
    in_tok.valid <= 1'b0;

    // Drain outstanding events, then let the pipeline settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending != 0) $error("%0d expected events never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> json_token_grammar_checker.f
rtl/jtg_pkg.sv
rtl/jtg_ifs.sv
rtl/jtg_ctx_stack.sv
rtl/jtg_grammar.sv
rtl/json_token_grammar_checker.sv
dv/jtg_tb_pkg.sv
dv/jtg_grammar_checker.sv
dv/json_token_grammar_checker_tb.sv
